@@ hdl/sr_pkg.sv @@
package sr_pkg;

  // Fixed field widths of the request, result and register
  localparam int unsigned NUM_W    = 11;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned STATUS_W = 2;

  // APB register map
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_NUM_PARTICLES = 1'b0;  // paddr[2]

  localparam logic [NUM_W-1:0] NUM_RESET = 11'd1024;

  // Parameter defaults
  localparam int unsigned MAX_PARTICLES_DEF = 1024;
  localparam int unsigned WEIGHT_BITS_DEF   = 32;
  localparam int unsigned OFFSET_BITS_DEF   = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO      = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_SEARCH
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [WEIGHT_W-1:0] weight;
    logic [OFFSET_W-1:0] offset;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               last;
    status_e            status;
  } res_t;

  // Control of the threshold accumulator
  typedef struct packed {
    logic clear;  // drop to zero
    logic init;   // latch offset, start serial multiply
    logic step;   // one shift-add bit
    logic bump;   // advance to next slot: add total << F
  } rhs_ctl_t;

endpackage

@@ hdl/sr_rhs.sv @@
// Threshold accumulator: offset*total by shift-add, one offset bit per cycle,
// then total << F added per slot.
module sr_rhs #(
  parameter int unsigned SUM_W  = 43,
  parameter int unsigned OW     = 16,
  parameter int unsigned FRAC_W = 16,
  parameter int unsigned RHS_W  = 70
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sr_pkg::rhs_ctl_t ctl_i,
  input  logic [SUM_W-1:0] total_i,
  input  logic [OW-1:0]    offset_i,
  output logic [RHS_W-1:0] rhs_o,
  output logic             done_o
);

  localparam int unsigned CW = $clog2(OW + 1);

  logic [RHS_W-1:0] acc_q, acc_d;
  logic [OW-1:0]    off_q, off_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [RHS_W-1:0] addend;

  always_comb begin
    acc_d  = acc_q;
    off_d  = off_q;
    cnt_d  = cnt_q;
    addend = '0;
    priority if (ctl_i.clear) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (ctl_i.init) begin
      acc_d = '0;
      off_d = offset_i;
      cnt_d = CW'(OW);
    end else if (ctl_i.step) begin
      if (off_q[OW-1]) begin
        addend = RHS_W'(total_i);
      end
      acc_d = {acc_q[RHS_W-2:0], 1'b0} + addend;
      off_d = {off_q[OW-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
    end else if (ctl_i.bump) begin
      addend = RHS_W'({total_i, {FRAC_W{1'b0}}});
      acc_d  = acc_q + addend;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
  end

  assign rhs_o  = acc_q;
  assign done_o = (cnt_q == '0);

endmodule

@@ hdl/systematic_resampler_top.sv @@
// Channel    Handshake                     Payload
// request    start / busy                  req_i  (op, weight, offset)
// result     res_strobe_o (one cycle)      res_o  (index, last, status)
// config     APB psel/penable/pwrite       paddr, pwdata, prdata
//
// Load: weight*N product registered, then summed and stored.
// Draw: answered straight from idle when not ready or zero total, else by cursor
// steps, after a serial offset*total multiply on the first draw of a round.
// Each result is registered before it reaches res_o.
// Reset clears control state and running sums; the cumulative store is not cleared.
// Results cannot be stalled: res_strobe_o marks a single cycle.
module systematic_resampler_top #(
  parameter int unsigned MAX_PARTICLES = sr_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned WEIGHT_BITS   = sr_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned OFFSET_BITS   = sr_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sr_pkg::ADDR_W-1:0]   paddr,
  input  logic [sr_pkg::PDATA_W-1:0]  pwdata,
  output logic [sr_pkg::PDATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  sr_pkg::req_t                req_i,
  output logic                        res_strobe_o,
  output sr_pkg::res_t                res_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned WW     = (WEIGHT_BITS < sr_pkg::WEIGHT_W) ?
                                   WEIGHT_BITS : sr_pkg::WEIGHT_W;
  localparam int unsigned OW     = (OFFSET_BITS < sr_pkg::OFFSET_W) ?
                                   OFFSET_BITS : sr_pkg::OFFSET_W;
  localparam int unsigned SUM_W  = WW + CNT_W;
  localparam int unsigned SSUM_W = SUM_W + CNT_W;
  localparam int unsigned CMP_W  = SSUM_W + OFFSET_BITS;
  localparam int unsigned N_RST  = (32'(sr_pkg::NUM_RESET) > MAX_PARTICLES) ?
                                   MAX_PARTICLES : 32'(sr_pkg::NUM_RESET);

  sr_pkg::state_e state_q, state_d;

  logic [sr_pkg::NUM_W-1:0] numreg_q;
  logic [CNT_W-1:0]         n_q, n_wr;
  logic [CNT_W-1:0]         loaded_q, loaded_d;
  logic [IDX_W-1:0]         slot_q, slot_d;
  logic [IDX_W-1:0]         cursor_q, cursor_d;
  logic [SUM_W-1:0]         total_q, total_d;
  logic [SSUM_W-1:0]        stotal_q, stotal_d;
  logic [WW-1:0]            weight_q;
  logic [SUM_W-1:0]         prod_q;
  logic [SSUM_W-1:0]        rdata_q;
  logic [SSUM_W-1:0]        store [MAX_PARTICLES];

  logic                     res_strobe_q, res_strobe_d;
  sr_pkg::res_t             res_q, res_d;

  logic                     cfg_wr, accept, is_draw, filled, zero_tot;
  logic                     slot_last, cur_adv;
  logic                     cap_load, wr_en, early, zdraw, cur_inc, sdone;
  logic                     round_end, slot_inc;
  logic [CMP_W-1:0]         lhs, rhs;
  logic                     rhs_done;
  sr_pkg::rhs_ctl_t         rhs_ctl;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = sr_pkg::PDATA_W'(numreg_q);
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == sr_pkg::REG_NUM_PARTICLES);

  // effective N is the register clamped to 1..MAX_PARTICLES
  always_comb begin
    if (pwdata[sr_pkg::NUM_W-1:0] == '0) begin
      n_wr = CNT_W'(1);
    end else if (32'(pwdata[sr_pkg::NUM_W-1:0]) > MAX_PARTICLES) begin
      n_wr = CNT_W'(MAX_PARTICLES);
    end else begin
      n_wr = CNT_W'(pwdata[sr_pkg::NUM_W-1:0]);
    end
  end

  // ---------------- status decode ----------------
  assign accept    = start && !busy;
  assign is_draw   = (req_i.op == sr_pkg::OP_DRAW);
  assign filled    = (loaded_q >= n_q);
  assign zero_tot  = (total_q == '0);
  assign slot_last = ((CNT_W'(slot_q) + CNT_W'(1)) >= n_q);
  assign lhs       = {rdata_q, {OFFSET_BITS{1'b0}}};
  assign cur_adv   = ((CNT_W'(cursor_q) + CNT_W'(1)) < n_q) && (lhs < rhs);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sr_pkg::S_IDLE: begin
        if (accept) begin
          if (!is_draw) begin
            if (!filled) begin
              state_d = sr_pkg::S_LOAD;
            end
          end else if (filled && !zero_tot) begin
            state_d = (slot_q == '0) ? sr_pkg::S_MUL : sr_pkg::S_SEARCH;
          end
        end
      end
      sr_pkg::S_LOAD:   state_d = sr_pkg::S_IDLE;
      sr_pkg::S_MUL: begin
        if (rhs_done) begin
          state_d = sr_pkg::S_SEARCH;
        end
      end
      sr_pkg::S_SEARCH: begin
        if (!cur_adv) begin
          state_d = sr_pkg::S_IDLE;
        end
      end
      default:          state_d = sr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    cap_load     = 1'b0;
    wr_en        = 1'b0;
    early        = 1'b0;
    zdraw        = 1'b0;
    cur_inc      = 1'b0;
    sdone        = 1'b0;
    rhs_ctl      = '0;
    unique case (state_q)
      sr_pkg::S_IDLE: begin
        busy     = 1'b0;
        cap_load = accept && !is_draw && !filled;
        early    = accept && is_draw && !filled;
        zdraw    = accept && is_draw && filled && zero_tot;
        rhs_ctl.init = accept && is_draw && filled && !zero_tot && (slot_q == '0);
      end
      sr_pkg::S_LOAD:   wr_en = 1'b1;
      sr_pkg::S_MUL:    rhs_ctl.step = !rhs_done;
      sr_pkg::S_SEARCH: begin
        cur_inc = cur_adv;
        sdone   = !cur_adv;
      end
      default: ;
    endcase
    round_end     = (sdone || zdraw) && slot_last;
    slot_inc      = (sdone || zdraw) && !slot_last;
    rhs_ctl.bump  = sdone && !slot_last;
    rhs_ctl.clear = round_end || cfg_wr;
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    loaded_d = loaded_q;
    slot_d   = slot_q;
    cursor_d = cursor_q;
    total_d  = total_q;
    stotal_d = stotal_q;
    if (cfg_wr || round_end) begin
      loaded_d = '0;
      slot_d   = '0;
      cursor_d = '0;
      total_d  = '0;
      stotal_d = '0;
    end else begin
      if (wr_en) begin
        loaded_d = loaded_q + CNT_W'(1);
        total_d  = total_q + SUM_W'(weight_q);
        stotal_d = stotal_q + SSUM_W'(prod_q);
      end
      if (slot_inc) begin
        slot_d = slot_q + IDX_W'(1);
      end
      if (cur_inc) begin
        cursor_d = cursor_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    res_strobe_d = early || zdraw || sdone;
    res_d        = res_q;
    if (early) begin
      res_d.index  = '0;
      res_d.last   = 1'b0;
      res_d.status = sr_pkg::STAT_NOT_READY;
    end else if (zdraw) begin
      res_d.index  = sr_pkg::INDEX_W'(slot_q);
      res_d.last   = slot_last;
      res_d.status = sr_pkg::STAT_ZERO;
    end else if (sdone) begin
      res_d.index  = sr_pkg::INDEX_W'(cursor_q);
      res_d.last   = slot_last;
      res_d.status = sr_pkg::STAT_OK;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sr_pkg::S_IDLE;
      numreg_q     <= sr_pkg::NUM_RESET;
      n_q          <= CNT_W'(N_RST);
      loaded_q     <= '0;
      slot_q       <= '0;
      cursor_q     <= '0;
      total_q      <= '0;
      stotal_q     <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      loaded_q     <= loaded_d;
      slot_q       <= slot_d;
      cursor_q     <= cursor_d;
      total_q      <= total_d;
      stotal_q     <= stotal_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_wr) begin
        numreg_q <= pwdata[sr_pkg::NUM_W-1:0];
        n_q      <= n_wr;
      end
    end
  end

  // weight * N is registered before it is summed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cap_load) begin
      weight_q <= req_i.weight[WW-1:0];
      prod_q   <= SUM_W'(req_i.weight[WW-1:0]) * SUM_W'(n_q);
    end
  end

  // cumulative store holds partial sums scaled by N
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[loaded_q[IDX_W-1:0]] <= stotal_d;
    end
    rdata_q <= store[cursor_d];
  end

  sr_rhs #(
    .SUM_W  (SUM_W),
    .OW     (OW),
    .FRAC_W (OFFSET_BITS),
    .RHS_W  (CMP_W)
  ) u_rhs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rhs_ctl),
    .total_i  (total_q),
    .offset_i (req_i.offset[OW-1:0]),
    .rhs_o    (rhs),
    .done_o   (rhs_done)
  );

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

@@ hdl/sr_checker.sv @@
module sr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [sr_pkg::ADDR_W-1:0]  paddr,
  input logic [sr_pkg::PDATA_W-1:0] pwdata,
  input logic [sr_pkg::PDATA_W-1:0] prdata,
  input logic                       pready,
  input logic                       start,
  input logic                       busy,
  input sr_pkg::req_t               req_i,
  input logic                       res_strobe_o,
  input sr_pkg::res_t               res_o
);

  // a load request never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == sr_pkg::OP_LOAD) |=> !res_strobe_o)
    else $error("result after load request");

  // not-ready results carry zero index and no last flag
  a_not_ready_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.status == sr_pkg::STAT_NOT_READY)
      |-> (res_o.index == '0 && !res_o.last))
    else $error("not-ready result with nonzero fields");

  // a result always comes out with the block idle again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !busy)
    else $error("result while busy");

  // register read back matches the last write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[2] == sr_pkg::REG_NUM_PARTICLES)
      |=> (prdata == sr_pkg::PDATA_W'($past(pwdata[sr_pkg::NUM_W-1:0]))))
    else $error("particle count read back mismatch");

endmodule

bind systematic_resampler_top sr_checker u_sr_checker (.*);

@@ verif/tb_systematic_resampler_top.sv @@
`timescale 1ns / 1ps

module tb_systematic_resampler_top;

  localparam int unsigned MAXP        = sr_pkg::MAX_PARTICLES_DEF;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned TAIL        = 32;
  localparam int unsigned RAND_ITEMS  = 950;
  localparam int unsigned QUIET_AFTER = 800;
  localparam logic [sr_pkg::WEIGHT_W-1:0] W_MAX = {sr_pkg::WEIGHT_W{1'b1}};
  localparam logic [sr_pkg::OFFSET_W-1:0] O_MAX = {sr_pkg::OFFSET_W{1'b1}};
  localparam logic [sr_pkg::ADDR_W-1:0] NUM_ADDR = {sr_pkg::REG_NUM_PARTICLES, 2'b00};
  localparam sr_pkg::op_e     LD   = sr_pkg::OP_LOAD;
  localparam sr_pkg::op_e     DR   = sr_pkg::OP_DRAW;
  localparam sr_pkg::status_e SOK  = sr_pkg::STAT_OK;
  localparam sr_pkg::status_e ZTOT = sr_pkg::STAT_ZERO;
  localparam sr_pkg::status_e NRDY = sr_pkg::STAT_NOT_READY;
  localparam sr_pkg::res_t NO_RES = '{10'd0, 1'b0, SOK};

  typedef enum logic {
    ACT_CFG,
    ACT_REQ
  } act_e;

  typedef struct packed {
    act_e                       act;
    logic [sr_pkg::PDATA_W-1:0] cfg;
    sr_pkg::req_t               r;
    logic                       typed;
    sr_pkg::res_t               want;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [sr_pkg::ADDR_W-1:0]  paddr = '0;
  logic [sr_pkg::PDATA_W-1:0] pwdata = '0;
  logic [sr_pkg::PDATA_W-1:0] prdata;
  logic                       pready;
  logic                       start = 1'b0;
  logic                       busy;
  sr_pkg::req_t               req = '{LD, 32'd0, 16'd0};
  logic                       res_strobe;
  sr_pkg::res_t               res;

  // mirror of the block
  logic [41:0]                 cum_sums [MAXP];
  logic [41:0]                 sum_total;
  logic [10:0]                 n_loaded;
  logic [9:0]                  slot;
  logic [9:0]                  cur;
  logic [sr_pkg::OFFSET_W-1:0] off_latched;
  logic [sr_pkg::NUM_W-1:0]    num_reg;

  sr_pkg::res_t pending_picks [$];
  sr_pkg::res_t want;
  int unsigned  fail_count = 0;
  int unsigned  reqs_sent = 0;
  bit           gaps_on = 1'b1;

  // directed stimulus; typed results only where obvious
  row_t dir_rows [24] = '{
    '{ACT_REQ, 32'd0, '{DR, 32'd0, O_MAX}, 1'b1, '{10'd0, 1'b0, NRDY}},
    '{ACT_CFG, 32'd1, '{LD, 32'd0, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, 32'd0, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, 16'd0}, 1'b1, '{10'd0, 1'b1, ZTOT}},
    '{ACT_REQ, 32'd0, '{LD, W_MAX, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, O_MAX}, 1'b1, '{10'd0, 1'b1, SOK}},
    '{ACT_CFG, 32'd3, '{LD, 32'd0, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, W_MAX, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, 32'd0, O_MAX}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, W_MAX, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, 32'd5, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, W_MAX, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, 16'h1234}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, O_MAX}, 1'b0, NO_RES},
    '{ACT_CFG, 32'd2047, '{LD, 32'd0, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, 16'h8000}, 1'b1, '{10'd0, 1'b0, NRDY}},
    '{ACT_CFG, 32'd0, '{LD, 32'd0, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, 32'd7, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, O_MAX}, 1'b1, '{10'd0, 1'b1, SOK}},
    '{ACT_CFG, 32'd2, '{LD, 32'd0, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{LD, 32'd1, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, 16'd0}, 1'b1, '{10'd0, 1'b0, NRDY}},
    '{ACT_REQ, 32'd0, '{LD, 32'd1, 16'd0}, 1'b0, NO_RES},
    '{ACT_REQ, 32'd0, '{DR, 32'd0, 16'h8000}, 1'b0, NO_RES}
  };

  systematic_resampler_top DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .req_i        (req),
    .res_strobe_o (res_strobe),
    .res_o        (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_round();
    sum_total   = '0;
    n_loaded    = '0;
    slot        = '0;
    cur         = '0;
    off_latched = '0;
  endfunction

  function automatic int unsigned eff_n();
    if (num_reg == 0) return 1;
    if (num_reg > MAXP) return MAXP;
    return 32'(num_reg);
  endfunction

  // Advances the mirror by one request; returns 1 when a result is due.
  function automatic bit pick_source(input sr_pkg::req_t r, output sr_pkg::res_t o);
    int unsigned  n;
    logic [127:0] scale;
    logic [127:0] target;
    bit           last_slot;
    n = eff_n();
    o = NO_RES;
    if (r.op == LD) begin
      if (n_loaded < n) begin
        sum_total = sum_total + 42'(r.weight);
        cum_sums[n_loaded[9:0]] = sum_total;
        n_loaded = n_loaded + 11'd1;
      end
      return 1'b0;
    end
    if (n_loaded < n) begin
      o.status = NRDY;
      return 1'b1;
    end
    if (slot == 0) off_latched = r.offset;
    last_slot = (slot >= n - 1);
    if (sum_total == 0) begin
      o.index  = slot;
      o.status = ZTOT;
    end else begin
      scale  = 128'(n) << sr_pkg::OFFSET_W;
      target = (128'(slot) << sr_pkg::OFFSET_W) + 128'(off_latched);
      // exact compare: cum * N * 2^F against (k * 2^F + offset) * total
      while (cur < n - 1 && 128'(cum_sums[cur]) * scale < target * 128'(sum_total))
        cur = cur + 10'd1;
      o.index  = cur;
      o.status = SOK;
    end
    o.last = last_slot;
    if (last_slot) clear_round();
    else slot = slot + 10'd1;
    return 1'b1;
  endfunction

  task automatic send(input sr_pkg::req_t r, input logic typed,
                      input sr_pkg::res_t typed_res);
    sr_pkg::res_t p;
    bit           has;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    has = pick_source(r, p);
    if (has) pending_picks.insert(pending_picks.size(), typed ? typed_res : p);
  endtask

  task automatic idle(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold off until every result is in and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic reg_write(input logic [sr_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    num_reg = data[sr_pkg::NUM_W-1:0];
    clear_round();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic feed(input sr_pkg::req_t r, input bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) idle($urandom_range(1, 19));
    if (gaps && $urandom_range(0, 255) == 0) drain();
    send(r, 1'b0, NO_RES);
    reqs_sent++;
  endtask

  task automatic play_round(input logic [sr_pkg::PDATA_W-1:0] wdata,
                            input int unsigned mode, input bit cut, input bit gaps);
    int unsigned  n;
    int unsigned  stop_at;
    int unsigned  done;
    int unsigned  loads;
    int unsigned  k;
    bit           early;
    sr_pkg::req_t r;
    drain();
    reg_write(wdata);
    n       = eff_n();
    stop_at = cut ? $urandom_range(1, 2 * n) : 3 * n + 8;
    early   = ($urandom_range(0, 4) == 0);
    done    = 0;
    loads   = 0;
    while (loads < n && done < stop_at) begin
      if (early && $urandom_range(0, 7) == 0) begin
        r = '{DR, 32'($urandom), 16'($urandom)};
        feed(r, gaps);
        done++;
      end
      r.op     = LD;
      r.offset = 16'($urandom);
      case (mode)
        0: r.weight = '0;
        1: r.weight = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'd0;
        2: r.weight = 32'($urandom_range(0, 15));
        3: r.weight = (loads == n - 1) ? W_MAX : 32'd0;
        default: r.weight = ($urandom_range(0, 15) == 0) ? W_MAX : 32'($urandom);
      endcase
      feed(r, gaps);
      done++;
      loads++;
    end
    // surplus loads once the round is full are dropped by the block
    if (loads == n && done < stop_at && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send(sr_pkg::req_t'{LD, 32'($urandom), 16'($urandom)}, 1'b0, NO_RES);
    for (k = 0; k < n && done < stop_at; k++) begin
      r.op     = DR;
      r.weight = 32'($urandom);
      case ($urandom_range(0, 7))
        0: r.offset = '0;
        1: r.offset = O_MAX;
        default: r.offset = 16'($urandom);
      endcase
      feed(r, gaps);
      done++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && res_strobe) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected result: index %0d last %0b status %0d",
               res.index, res.last, res.status);
        fail_count++;
      end else begin
        want = pending_picks.pop_front();
        if (res.index !== want.index) begin
          $error("index: expected %0d, got %0d", want.index, res.index);
          fail_count++;
        end
        if (res.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res.last);
          fail_count++;
        end
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned                nval;
    logic [sr_pkg::PDATA_W-1:0] wdata;
    clear_round();
    num_reg = sr_pkg::NUM_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].act == ACT_CFG) begin
        drain();
        reg_write(dir_rows[i].cfg);
      end else begin
        send(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    while (reqs_sent < RAND_ITEMS) begin
      gaps_on = (reqs_sent < QUIET_AFTER);
      case ($urandom_range(0, 19))
        0: nval = 0;
        1: nval = $urandom_range(64, 128);
        2, 3, 4, 5, 6, 7, 8, 9, 10: nval = $urandom_range(1, 8);
        default: nval = $urandom_range(9, 40);
      endcase
      wdata = {(($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'd0), 11'(nval)};
      play_round(wdata, $urandom_range(0, 9), $urandom_range(0, 9) == 0,
                 gaps_on && $urandom_range(0, 3) != 0);
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (pending_picks.size() != 0) begin
      $error("%0d results never arrived", pending_picks.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
